/* rtl/bsr_pkg.sv */
// byte stack with rotate: shared types and codes
// used by bsr_seq and byte_stack_with_rotate; no dependencies
package bsr_pkg;

  // operation codes carried by the kind field
  typedef enum logic [2:0] {
    KIND_PUSH  = 3'd0,
    KIND_POP   = 3'd1,
    KIND_PEEK  = 3'd2,
    KIND_DUP   = 3'd3,
    KIND_UPROT = 3'd4,
    KIND_DNROT = 3'd5
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DEEP  = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_ROT_HOLD,
    S_ROT_MOVE,
    S_ROT_LAST,
    S_FINISH
  } state_t;

  // one result beat handed from the sequencer to the output register
  typedef struct packed {
    logic [7:0] read_value;
    status_t    status;
    logic [7:0] entry_count;
  } result_t;

endpackage

/* rtl/bsr_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/bsr_seq.sv */
// byte stack sequencer: decodes one operation and steps the shared
// pointer unit over the entry RAM; uses bsr_pkg
module bsr_seq #(
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_kind,
  input  logic [7:0]               in_push_value,
  input  logic [7:0]               in_rotate_depth,
  output logic                     ram_we,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
  output logic [7:0]               ram_wdata,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_raddr,
  input  logic [7:0]               ram_rdata,
  output logic                     res_valid,
  output bsr_pkg::result_t         res,
  input  logic                     res_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > 8) ? CW : 8;

  bsr_pkg::state_t  state_r, state_nxt;
  bsr_pkg::kind_t   kind_r, kind_nxt;
  bsr_pkg::status_t status_r, status_nxt;
  logic [7:0]       value_r, value_nxt;
  logic [7:0]       m_r, m_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [7:0]       rdval_r, rdval_nxt;

  logic             is_full;
  logic             is_empty;
  logic             too_deep;
  logic             up_dir;
  logic [AW-1:0]    top_addr;
  logic [AW-1:0]    base_addr;
  logic [AW-1:0]    fill_addr;
  logic [MW-1:0]    m_ext;
  logic [MW-1:0]    count_ext;

  // shared pointer step: toward the bottom for up-rotate, toward the top otherwise
  function automatic logic [AW-1:0] ptr_step(input logic [AW-1:0] p, input logic dn);
    ptr_step = dn ? (p - AW'(1)) : (p + AW'(1));
  endfunction

  // stack geometry
  assign m_ext     = MW'(m_r);
  assign count_ext = MW'(count_r);
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign too_deep  = (m_ext > count_ext);
  assign up_dir    = (kind_r == bsr_pkg::KIND_UPROT);
  assign top_addr  = AW'(count_r - CW'(1));
  assign base_addr = AW'(count_ext - m_ext);
  assign fill_addr = AW'(count_r);

  assign in_stall = (state_r != bsr_pkg::S_IDLE);

  // result beat
  assign res.read_value  = rdval_r;
  assign res.status      = status_r;
  assign res.entry_count = 8'(count_r);

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsr_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // operation payload registers
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    m_r      <= m_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    rem_r    <= rem_nxt;
    held_r   <= held_nxt;
    rdval_r  <= rdval_nxt;
  end

  // next state and ram control
  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    m_nxt      = m_r;
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    rem_nxt    = rem_r;
    held_nxt   = held_r;
    rdval_nxt  = rdval_r;
    ram_we     = 1'b0;
    ram_waddr  = wr_ptr_r;
    ram_wdata  = held_r;
    ram_raddr  = rd_ptr_r;
    res_valid  = 1'b0;

    case (state_r)
      bsr_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = bsr_pkg::kind_t'(in_kind);
          value_nxt  = in_push_value;
          m_nxt      = in_rotate_depth;
          rdval_nxt  = 8'd0;
          status_nxt = bsr_pkg::ST_OK;
          state_nxt  = bsr_pkg::S_DECODE;
        end
      end

      bsr_pkg::S_DECODE: begin
        state_nxt = bsr_pkg::S_FINISH;
        case (kind_r)
          bsr_pkg::KIND_PUSH: begin
            if (is_full) begin
              status_nxt = bsr_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = fill_addr;
              ram_wdata = value_r;
              count_nxt = count_r + CW'(1);
            end
          end
          bsr_pkg::KIND_POP, bsr_pkg::KIND_PEEK: begin
            if (is_empty) begin
              status_nxt = bsr_pkg::ST_EMPTY;
            end else begin
              ram_raddr = top_addr;
              state_nxt = bsr_pkg::S_FETCH;
            end
          end
          bsr_pkg::KIND_DUP: begin
            if (is_empty) begin
              status_nxt = bsr_pkg::ST_EMPTY;
            end else if (is_full) begin
              status_nxt = bsr_pkg::ST_FULL;
            end else begin
              ram_raddr = top_addr;
              state_nxt = bsr_pkg::S_FETCH;
            end
          end
          bsr_pkg::KIND_UPROT, bsr_pkg::KIND_DNROT: begin
            if (too_deep) begin
              status_nxt = bsr_pkg::ST_DEEP;
            end else if (m_r >= 8'd2) begin
              // fetch the entry that wraps around, then walk the rest
              ram_raddr  = up_dir ? top_addr : base_addr;
              rd_ptr_nxt = up_dir ? (top_addr - AW'(1)) : (base_addr + AW'(1));
              wr_ptr_nxt = up_dir ? top_addr : base_addr;
              rem_nxt    = m_r - 8'd1;
              state_nxt  = bsr_pkg::S_ROT_HOLD;
            end
          end
          default: begin
          end
        endcase
      end

      bsr_pkg::S_FETCH: begin
        state_nxt = bsr_pkg::S_FINISH;
        case (kind_r)
          bsr_pkg::KIND_POP: begin
            rdval_nxt = ram_rdata;
            count_nxt = count_r - CW'(1);
          end
          bsr_pkg::KIND_PEEK: begin
            rdval_nxt = ram_rdata;
          end
          bsr_pkg::KIND_DUP: begin
            ram_we    = 1'b1;
            ram_waddr = fill_addr;
            ram_wdata = ram_rdata;
            count_nxt = count_r + CW'(1);
          end
          default: begin
          end
        endcase
      end

      // hold the wrapping entry and start the first move read
      bsr_pkg::S_ROT_HOLD: begin
        held_nxt   = ram_rdata;
        ram_raddr  = rd_ptr_r;
        rd_ptr_nxt = ptr_step(rd_ptr_r, up_dir);
        state_nxt  = bsr_pkg::S_ROT_MOVE;
      end

      // one entry shifted per cycle, next read overlapped with this write
      bsr_pkg::S_ROT_MOVE: begin
        ram_we     = 1'b1;
        ram_waddr  = wr_ptr_r;
        ram_wdata  = ram_rdata;
        wr_ptr_nxt = ptr_step(wr_ptr_r, up_dir);
        ram_raddr  = rd_ptr_r;
        rd_ptr_nxt = ptr_step(rd_ptr_r, up_dir);
        rem_nxt    = rem_r - 8'd1;
        if (rem_r == 8'd1) begin
          state_nxt = bsr_pkg::S_ROT_LAST;
        end
      end

      // drop the held entry into the vacated end
      bsr_pkg::S_ROT_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_r;
        ram_wdata = held_r;
        state_nxt = bsr_pkg::S_FINISH;
      end

      bsr_pkg::S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = bsr_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bsr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/byte_stack_with_rotate.sv */
// byte stack with push, pop, peek, duplicate and rotates: top level
// holds the entry RAM, the sequencer and the result register; uses bsr_pkg,
// bsr_ram and bsr_seq
//
//   channel  direction  fields                                 handshake
//   in_      input      kind, push_value, rotate_depth         in_valid / in_stall
//   out_     output     read_value, status, entry_count        out_valid / out_stall
//
// push, shallow rotates and all error or no-op cases go from decode straight to
// finish; pop, peek and duplicate add a fetch step; a rotate of depth m moves
// one RAM entry per cycle through the single write and read port.
// reset empties the stack at once; entry RAM contents are not cleared.
// a held result in the output register stalls only the final step; once the
// result moves there, a new beat is taken while the previous result still waits.
module byte_stack_with_rotate #(
  parameter int DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_push_value,
  input  logic [7:0] in_rotate_depth,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_value,
  output logic [1:0] out_status,
  output logic [7:0] out_entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;
  logic             res_valid;
  logic             res_ready;
  bsr_pkg::result_t res;
  bsr_pkg::result_t out_r;
  logic             out_valid_r;

  // entry storage
  bsr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // operation sequencer
  bsr_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_push_value   (in_push_value),
    .in_rotate_depth (in_rotate_depth),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready)
  );

  // result register frees up when empty or when its beat is taken
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_r.read_value;
  assign out_status      = out_r.status;
  assign out_entry_count = out_r.entry_count;

endmodule

/* bench/byte_stack_with_rotate_tb.sv */
// testbench for byte_stack_with_rotate: directed and random stack operations
// checked against an in-bench stack predictor; depends on bsr_pkg and the rtl top
module byte_stack_with_rotate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 128;
  // kinds with no operation behind them
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_kind = '0;
  logic [7:0] in_push_value = '0;
  logic [7:0] in_rotate_depth = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_value;
  logic [1:0] out_status;
  logic [7:0] out_entry_count;

  // predicted stack contents and fill level
  logic [7:0] shadow_stack [STACK_DEPTH];
  int         shadow_fill = 0;

  bsr_pkg::result_t pending_results [$];
  int         fail_count = 0;

  // idling controls
  bit         tx_idle_en = 1'b0;
  bit         rx_idle_en = 1'b0;
  int         hold_req = 0;
  int         hold_left = 0;
  int         burst_left = 0;

  byte_stack_with_rotate #(.DEPTH(STACK_DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_push_value  (in_push_value),
    .in_rotate_depth(in_rotate_depth),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  always #5 clk = ~clk;

  // apply one operation to the shadow stack and return the expected result
  function automatic bsr_pkg::result_t stack_apply(input logic [2:0] kind,
                                                   input logic [7:0] value,
                                                   input logic [7:0] depth);
    bsr_pkg::result_t res;
    int         top;
    int         base;
    logic [7:0] held;
    res.read_value = '0;
    res.status = bsr_pkg::ST_OK;
    case (kind)
      bsr_pkg::KIND_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          res.status = bsr_pkg::ST_FULL;
        end else begin
          shadow_stack[shadow_fill] = value;
          shadow_fill++;
        end
      end
      bsr_pkg::KIND_POP: begin
        if (shadow_fill == 0) begin
          res.status = bsr_pkg::ST_EMPTY;
        end else begin
          shadow_fill--;
          res.read_value = shadow_stack[shadow_fill];
        end
      end
      bsr_pkg::KIND_PEEK: begin
        if (shadow_fill == 0) res.status = bsr_pkg::ST_EMPTY;
        else res.read_value = shadow_stack[shadow_fill - 1];
      end
      bsr_pkg::KIND_DUP: begin
        // emptiness is tested before fullness
        if (shadow_fill == 0) begin
          res.status = bsr_pkg::ST_EMPTY;
        end else if (shadow_fill >= STACK_DEPTH) begin
          res.status = bsr_pkg::ST_FULL;
        end else begin
          shadow_stack[shadow_fill] = shadow_stack[shadow_fill - 1];
          shadow_fill++;
        end
      end
      bsr_pkg::KIND_UPROT, bsr_pkg::KIND_DNROT: begin
        if (int'(depth) > shadow_fill) begin
          res.status = bsr_pkg::ST_DEEP;
        end else if (depth >= 2) begin
          top = shadow_fill - 1;
          base = shadow_fill - int'(depth);
          if (kind == bsr_pkg::KIND_UPROT) begin
            // top entry sinks to depth m
            held = shadow_stack[top];
            for (int i = top; i > base; i--) shadow_stack[i] = shadow_stack[i - 1];
            shadow_stack[base] = held;
          end else begin
            // entry at depth m rises to the top
            held = shadow_stack[base];
            for (int i = base; i < top; i++) shadow_stack[i] = shadow_stack[i + 1];
            shadow_stack[top] = held;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = shadow_fill[7:0];
    return res;
  endfunction

  // offer one beat, wait for it to be taken, then record its expected result
  task automatic send_beat(input logic [2:0] kind, input logic [7:0] value,
                           input logic [7:0] depth);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_push_value <= value;
    in_rotate_depth <= depth;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(stack_apply(kind, value, depth));
  endtask

  // one random operation; push_heavy steers the fill level up or down
  task automatic send_random_op(input bit push_heavy);
    int         pick;
    int         reach;
    logic [2:0] kind;
    logic [7:0] depth;
    pick = $urandom_range(0, 99);
    if (push_heavy) begin
      if (pick < 40) kind = bsr_pkg::KIND_PUSH;
      else if (pick < 50) kind = bsr_pkg::KIND_DUP;
      else if (pick < 62) kind = bsr_pkg::KIND_POP;
      else if (pick < 72) kind = bsr_pkg::KIND_PEEK;
      else if (pick < 83) kind = bsr_pkg::KIND_UPROT;
      else if (pick < 94) kind = bsr_pkg::KIND_DNROT;
      else kind = (pick < 97) ? KIND_SPARE_6 : KIND_SPARE_7;
    end else begin
      if (pick < 15) kind = bsr_pkg::KIND_PUSH;
      else if (pick < 20) kind = bsr_pkg::KIND_DUP;
      else if (pick < 55) kind = bsr_pkg::KIND_POP;
      else if (pick < 65) kind = bsr_pkg::KIND_PEEK;
      else if (pick < 78) kind = bsr_pkg::KIND_UPROT;
      else if (pick < 91) kind = bsr_pkg::KIND_DNROT;
      else kind = (pick < 96) ? KIND_SPARE_6 : KIND_SPARE_7;
    end
    // rotate depths mostly shallow, some up to one past the fill level, a few anywhere
    reach = (shadow_fill + 1 > STACK_DEPTH) ? STACK_DEPTH : shadow_fill + 1;
    pick = $urandom_range(0, 99);
    if (kind != bsr_pkg::KIND_UPROT && kind != bsr_pkg::KIND_DNROT)
      depth = 8'($urandom_range(0, STACK_DEPTH));
    else if (pick < 60) depth = 8'($urandom_range(0, (reach < 8) ? reach : 8));
    else if (pick < 85) depth = 8'($urandom_range(0, reach));
    else depth = 8'($urandom_range(0, STACK_DEPTH));
    send_beat(kind, 8'($urandom_range(0, 255)), depth);
  endtask

  // receiver stall: long hold on request, otherwise random bursts
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    bsr_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: read_value %0d status %0d count %0d",
               out_read_value, out_status, out_entry_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          fail_count++;
        end
      end
    end
  end

  // every operation but push on an empty stack, plus the spare kinds
  task automatic test_empty_stack();
    send_beat(bsr_pkg::KIND_POP, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_PEEK, 8'hFF, 8'd0);
    send_beat(bsr_pkg::KIND_DUP, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_UPROT, 8'h00, 8'd1);
    send_beat(bsr_pkg::KIND_DNROT, 8'h00, 8'd2);
    send_beat(bsr_pkg::KIND_UPROT, 8'h00, 8'd0);
    send_beat(KIND_SPARE_6, 8'hFF, 8'd128);
    send_beat(KIND_SPARE_7, 8'h55, 8'd127);
  endtask

  // extreme bytes, peek, duplicate, rotates shallow, exact and too deep
  task automatic test_basic_ops();
    send_beat(bsr_pkg::KIND_PUSH, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_PUSH, 8'hFF, 8'd0);
    send_beat(bsr_pkg::KIND_PUSH, 8'hA5, 8'd0);
    send_beat(bsr_pkg::KIND_PUSH, 8'h5A, 8'd0);
    send_beat(bsr_pkg::KIND_PEEK, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_DUP, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_UPROT, 8'h00, 8'd3);
    send_beat(bsr_pkg::KIND_DNROT, 8'h00, 8'd5);
    send_beat(bsr_pkg::KIND_DNROT, 8'h00, 8'd6);
    send_beat(bsr_pkg::KIND_UPROT, 8'h00, 8'd1);
    send_beat(bsr_pkg::KIND_DNROT, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_UPROT, 8'h00, 8'd5);
    send_beat(bsr_pkg::KIND_POP, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_POP, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_PEEK, 8'h00, 8'd0);
  endtask

  // fill to the limit, reject on full, rotate the whole stack, drain past empty
  task automatic test_full_stack();
    while (shadow_fill < STACK_DEPTH)
      send_beat(bsr_pkg::KIND_PUSH, 8'($urandom_range(0, 255)), 8'd0);
    send_beat(bsr_pkg::KIND_PUSH, 8'hFF, 8'd0);
    send_beat(bsr_pkg::KIND_DUP, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_UPROT, 8'h00, 8'd128);
    send_beat(bsr_pkg::KIND_PEEK, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_DNROT, 8'h00, 8'd128);
    send_beat(bsr_pkg::KIND_PEEK, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_DNROT, 8'h00, 8'd127);
    send_beat(bsr_pkg::KIND_UPROT, 8'h00, 8'd2);
    while (shadow_fill > 0) send_beat(bsr_pkg::KIND_POP, 8'h00, 8'd0);
    send_beat(bsr_pkg::KIND_POP, 8'h00, 8'd0);
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req = 300;
    repeat (24) send_random_op(1'b1);
  endtask

  // random mix with idling on both sides, alternating fill direction
  task automatic test_random_mix();
    int  run_left;
    bit  push_heavy;
    run_left = 0;
    push_heavy = 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (40) begin
      if (run_left == 0) begin
        push_heavy = ~push_heavy;
        run_left = $urandom_range(20, 60);
      end
      run_left--;
      send_random_op(push_heavy);
    end
  endtask

  // closing stretch at full rate, no idling anywhere
  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (30) send_random_op(1'b1);
    repeat (30) send_random_op(1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack();
    test_basic_ops();
    test_full_stack();
    test_backpressure();
    test_random_mix();
    test_streaming();
    in_valid <= 1'b0;
    // drain, then give stray beats time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // overall run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
